FILE: hdl/sdtq_pkg.sv
package sdtq_pkg;

  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned MaxResults   = 16;

  localparam logic [1:0] FuncSchedule   = 2'd0;
  localparam logic [1:0] FuncUnschedule = 2'd1;
  localparam logic [1:0] FuncQuery      = 2'd2;
  localparam logic [1:0] FuncExpire     = 2'd3;

  // One timer entry as it sits in the memory.
  typedef struct packed {
    logic [31:0] deadline;
    logic [15:0] id;
    logic [31:0] param;
  } entry_t;

  // True when a is strictly earlier than b in wrap-around order.
  function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff[31];
  endfunction

endpackage

FILE: hdl/sorted_deadline_timer_queue_core.sv
// Sorted deadline timer queue.
//
// The slave stream (s_axis_*) carries one command beat: schedule, unschedule,
// query or expire (in tuser), together with the current time. The master
// stream (m_axis_*) returns result beats. Every command yields one beat,
// except expire, which yields one beat per popped timer (up to 16, fired in
// tuser) or one unfired beat if none is due; m_axis_tlast marks the final
// beat of a command, which also carries the time to the next deadline.
//
// All timers live in one synchronous memory of SLOTS entries, sorted by
// deadline. Each command walks the memory one entry at a time: a search
// pass reads entries 0..count-1, and an insert or remove shifts the tail
// one entry at a time (read in one cycle, write the neighbor the next).
// One command is worked on at a time; the next beat is accepted once the
// final result sits in the output register.
//
// A fired beat is held back until the next head has been checked, so that the
// final one can carry tlast and the wait value. The block stalls in place
// while the result register is full and m_axis_tready is low; no state is
// lost. Reset clears the entry count and control state; memory contents are
// not cleared, because entries at or above the count are never used.
module sorted_deadline_timer_queue_core #(
  parameter int unsigned SLOTS = sdtq_pkg::SlotsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata fields from bit 0: now[31:0], delta[63:32], task_id[79:64],
  // task_param[111:80], match_param[112], zeros to 119.
  input  logic [119:0] s_axis_tdata,
  // tuser fields from bit 0: func[1:0].
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata fields from bit 0: ok[0], fired_id[16:1], fired_param[48:17],
  // wait_to_next[80:49], zeros to 87.
  output logic [87:0]  m_axis_tdata,
  // tuser fields from bit 0: fired[0].
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);
  import sdtq_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StSearch  = 4'd1;
  localparam logic [3:0] StSrchChk = 4'd2;
  localparam logic [3:0] StRemRd   = 4'd3;
  localparam logic [3:0] StRemWr   = 4'd4;
  localparam logic [3:0] StInsRd   = 4'd5;
  localparam logic [3:0] StInsChk  = 4'd6;
  localparam logic [3:0] StHeadRd  = 4'd7;
  localparam logic [3:0] StHeadChk = 4'd8;
  localparam logic [3:0] StExpRd   = 4'd9;
  localparam logic [3:0] StExpChk  = 4'd10;

  entry_t mem [SLOTS];
  entry_t rd_data_q;

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [4:0]      popped_q, popped_d;
  logic            found_q, found_d;

  logic [1:0]  func_q;
  logic [31:0] now_q, dl_q;
  logic [15:0] id_q;
  logic [31:0] par_q;
  logic        usep_q;

  logic        rd_en, wr_en;
  logic [IdxW-1:0] rd_addr, wr_addr;
  entry_t      wr_data;

  logic        ov_q, ov_d;
  logic [87:0] ot_q, ot_d;
  logic        ou_q, ou_d;
  logic        ol_q, ol_d;
  logic        out_free;

  // Fired beat waiting until it is known whether it is the final one.
  logic        pend_q, pend_d;
  logic [15:0] pid_q, pid_d;
  logic [31:0] ppar_q, ppar_d;

  logic        match;
  logic [31:0] wait_val;
  logic [31:0] wdiff;

  assign out_free      = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = ot_q;
  assign m_axis_tuser  = ou_q;
  assign m_axis_tlast  = ol_q;

  assign match = (rd_data_q.id == id_q) && (!usep_q || rd_data_q.param == par_q);
  assign wdiff = rd_data_q.deadline - now_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func_q <= s_axis_tuser;
      now_q  <= s_axis_tdata[31:0];
      dl_q   <= s_axis_tdata[31:0] + s_axis_tdata[63:32];
      id_q   <= s_axis_tdata[79:64];
      par_q  <= s_axis_tdata[111:80];
      usep_q <= s_axis_tdata[112];
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    popped_d = popped_q;
    found_d  = found_q;
    pend_d   = pend_q;
    pid_d    = pid_q;
    ppar_d   = ppar_q;
    ov_d     = ov_q && !m_axis_tready;
    ot_d     = ot_q;
    ou_d     = ou_q;
    ol_d     = ol_q;
    rd_en    = 1'b0;
    rd_addr  = ptr_q[IdxW-1:0];
    wr_en    = 1'b0;
    wr_addr  = ptr_q[IdxW-1:0];
    wr_data  = rd_data_q;
    // Wait to the head deadline; overdue gives zero, an empty queue all ones.
    if (count_q == '0) begin
      wait_val = 32'hFFFF_FFFF;
    end else begin
      wait_val = wdiff[31] ? 32'd0 : wdiff;
    end
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          ptr_d    = '0;
          popped_d = '0;
          found_d  = 1'b0;
          pend_d   = 1'b0;
          state_d  = (s_axis_tuser == FuncExpire) ? StExpRd : StSearch;
        end
      end
      StSearch: begin
        if (ptr_q < count_q) begin
          rd_en   = 1'b1;
          state_d = StSrchChk;
        end else begin
          priority if (func_q == FuncSchedule) begin
            ptr_d   = count_q;
            state_d = (count_q < CntW'(SLOTS)) ? StInsRd : StHeadRd;
          end else begin
            state_d = StHeadRd;
          end
        end
      end
      StSrchChk: begin
        if (match) begin
          found_d = 1'b1;
          priority if (func_q == FuncQuery) begin
            state_d = StHeadRd;
          end else begin
            state_d = StRemRd;
          end
        end else begin
          ptr_d   = ptr_q + 1'b1;
          state_d = StSearch;
        end
      end
      // Remove the entry at ptr: copy ptr+1 down to ptr until the tail.
      StRemRd: begin
        if (ptr_q + 1'b1 < count_q) begin
          rd_en   = 1'b1;
          rd_addr = IdxW'(ptr_q + 1'b1);
          state_d = StRemWr;
        end else begin
          count_d = count_q - 1'b1;
          priority if (func_q == FuncExpire) begin
            state_d = StExpRd;
          end else if (func_q == FuncSchedule) begin
            ptr_d   = count_q - 1'b1;
            state_d = StInsRd;
          end else begin
            state_d = StHeadRd;
          end
        end
      end
      StRemWr: begin
        wr_en   = 1'b1;
        ptr_d   = ptr_q + 1'b1;
        state_d = StRemRd;
      end
      // Insert: ptr is the free slot; shift later entries up by one.
      StInsRd: begin
        if (ptr_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = IdxW'(ptr_q - 1'b1);
          state_d = StInsChk;
        end else begin
          wr_en   = 1'b1;
          wr_data = '{deadline: dl_q, id: id_q, param: par_q};
          count_d = count_q + 1'b1;
          found_d = 1'b1;
          state_d = StHeadRd;
        end
      end
      StInsChk: begin
        if (earlier(dl_q, rd_data_q.deadline)) begin
          wr_en   = 1'b1;
          ptr_d   = ptr_q - 1'b1;
          state_d = StInsRd;
        end else begin
          wr_en   = 1'b1;
          wr_data = '{deadline: dl_q, id: id_q, param: par_q};
          count_d = count_q + 1'b1;
          found_d = 1'b1;
          state_d = StHeadRd;
        end
      end
      StHeadRd: begin
        rd_en   = 1'b1;
        rd_addr = '0;
        state_d = StHeadChk;
      end
      StHeadChk: begin
        if (out_free) begin
          ov_d = 1'b1;
          ol_d = 1'b1;
          ou_d = 1'b0;
          ot_d = '0;
          // A schedule sets found only when it inserted; unschedule reports 0.
          ot_d[0]     = found_q && (func_q != FuncUnschedule);
          ot_d[80:49] = wait_val;
          state_d     = StIdle;
        end
      end
      StExpRd: begin
        rd_en   = 1'b1;
        rd_addr = '0;
        state_d = StExpChk;
      end
      StExpChk: begin
        if (count_q != '0 && popped_q < 5'(MaxResults) &&
            !earlier(now_q, rd_data_q.deadline)) begin
          // Another timer is due, so a held beat is not the final one.
          if (!pend_q || out_free) begin
            if (pend_q) begin
              ov_d        = 1'b1;
              ol_d        = 1'b0;
              ou_d        = 1'b1;
              ot_d        = '0;
              ot_d[16:1]  = pid_q;
              ot_d[48:17] = ppar_q;
            end
            pend_d   = 1'b1;
            pid_d    = rd_data_q.id;
            ppar_d   = rd_data_q.param;
            popped_d = popped_q + 1'b1;
            ptr_d    = '0;
            state_d  = StRemRd;
          end
        end else if (out_free) begin
          ov_d = 1'b1;
          ol_d = 1'b1;
          ou_d = pend_q;
          ot_d = '0;
          if (pend_q) begin
            ot_d[16:1]  = pid_q;
            ot_d[48:17] = ppar_q;
          end
          ot_d[80:49] = wait_val;
          pend_d      = 1'b0;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      ptr_q    <= '0;
      popped_q <= '0;
      found_q  <= 1'b0;
      pend_q   <= 1'b0;
      pid_q    <= '0;
      ppar_q   <= '0;
      ov_q     <= 1'b0;
      ol_q     <= 1'b0;
      ou_q     <= 1'b0;
      ot_q     <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      popped_q <= popped_d;
      found_q  <= found_d;
      pend_q   <= pend_d;
      pid_q    <= pid_d;
      ppar_q   <= ppar_d;
      ov_q     <= ov_d;
      ol_q     <= ol_d;
      ou_q     <= ou_d;
      ot_q     <= ot_d;
    end
  end

endmodule
